@@ rtl/vbp_pkg.sv @@
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared widths, register map codes and helpers for the vertex brush core.
// ----------------------------------------------------------------------------
package vbp_pkg;

	localparam int CoordWidthDefault = 24;
	localparam int FracBitsDefault   = 8;

	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int RADIUS_W  = 15;
	localparam int STRENGTH_W = 15;
	localparam int STEP_W    = 16;
	localparam int CHAN_W    = 2;
	localparam int DIST_W    = 15;
	localparam int R2_W      = 2 * RADIUS_W;
	localparam int KFAC_W    = STEP_W + STRENGTH_W + 1;
	localparam int PROD_W    = R2_W + KFAC_W;
	localparam int QUOT_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int CSUM_W    = 14;

	localparam logic [2:0] REG_BRUSH_MODE     = 3'd0;
	localparam logic [2:0] REG_BRUSH_RADIUS   = 3'd1;
	localparam logic [2:0] REG_BRUSH_STRENGTH = 3'd2;
	localparam logic [2:0] REG_PAINT_CHANNEL  = 3'd3;
	localparam logic [2:0] REG_STEP_TIME      = 3'd4;

	localparam logic [RADIUS_W-1:0]   RadiusReset   = 15'd256;
	localparam logic [STRENGTH_W-1:0] StrengthReset = 15'd256;

	localparam logic signed [1:0] DIR_UP   = 2'sb01;
	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;
	localparam logic signed [1:0] DIR_DBL  = 2'sb10;

	function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [CSUM_W-1:0] v);
		logic [BYTE_W-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed(CSUM_W'(255)))
			r = 8'hFF;
		else
			r = v[BYTE_W-1:0];
		return r;
	endfunction

endpackage

@@ rtl/vertex_brush_paint_core.sv @@
// ----------------------------------------------------------------------------
// vertex_brush_paint_core
// Circular terrain brush: height edit or splat colour paint, one vertex per item.
// ----------------------------------------------------------------------------
// One vertex item enters every cycle unless vertex_stall is high. The height
// path sets the depth: distance and squared radius, the falloff product,
// then a 16-stage restoring divider that yields one quotient bit per stage.
// A stalled result freezes the whole pipe; no item is lost. The user writes
// registers over the APB port only while no item is in flight; not enforced.
module vertex_brush_paint_core #(
	parameter int COORD_WIDTH = vbp_pkg::CoordWidthDefault,
	parameter int FRAC_BITS   = vbp_pkg::FracBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [vbp_pkg::PADDR_W-1:0]       paddr,
	input  logic [vbp_pkg::PDATA_W-1:0]       pwdata,
	output logic [vbp_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              vertex_valid,
	output logic                              vertex_stall,
	input  logic signed [COORD_WIDTH-1:0]     vertex_x,
	input  logic signed [COORD_WIDTH-1:0]     vertex_z,
	input  logic signed [COORD_WIDTH-1:0]     vertex_height,
	input  logic [31:0]                       vertex_color,
	input  logic signed [COORD_WIDTH-1:0]     hit_x,
	input  logic signed [COORD_WIDTH-1:0]     hit_z,
	input  logic signed [1:0]                 stroke_direction,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [COORD_WIDTH-1:0]     new_height,
	output logic [31:0]                       new_color,
	output logic                              inside_brush
);

	localparam int CW     = COORD_WIDTH;
	localparam int R2W    = vbp_pkg::R2_W;
	localparam int QW     = vbp_pkg::QUOT_W;
	localparam int CSW    = vbp_pkg::CSUM_W;
	localparam int HSW    = CW + 2;

	typedef struct packed {
		logic [R2W-1:0]        r2;
		logic signed [CW-1:0]  vh;
		logic [31:0]           col;
		logic                  hen;
		logic                  neg;
		logic                  in_brush;
	} carry_t;

	// configuration registers
	logic                               mode_q;
	logic [vbp_pkg::RADIUS_W-1:0]       radius_q;
	logic [vbp_pkg::STRENGTH_W-1:0]     strength_q;
	logic [vbp_pkg::CHAN_W-1:0]         chan_q;
	logic [vbp_pkg::STEP_W-1:0]         step_q;
	logic                               cfg_wr;
	logic [2:0]                         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			radius_q   <= vbp_pkg::RadiusReset;
			strength_q <= vbp_pkg::StrengthReset;
			chan_q     <= '0;
			step_q     <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				vbp_pkg::REG_BRUSH_MODE:     mode_q     <= pwdata[0];
				vbp_pkg::REG_BRUSH_RADIUS:   radius_q   <= pwdata[vbp_pkg::RADIUS_W-1:0];
				vbp_pkg::REG_BRUSH_STRENGTH: strength_q <= pwdata[vbp_pkg::STRENGTH_W-1:0];
				vbp_pkg::REG_PAINT_CHANNEL:  chan_q     <= pwdata[vbp_pkg::CHAN_W-1:0];
				vbp_pkg::REG_STEP_TIME:      step_q     <= pwdata[vbp_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			vbp_pkg::REG_BRUSH_MODE:     prdata = {31'd0, mode_q};
			vbp_pkg::REG_BRUSH_RADIUS:   prdata = {17'd0, radius_q};
			vbp_pkg::REG_BRUSH_STRENGTH: prdata = {17'd0, strength_q};
			vbp_pkg::REG_PAINT_CHANNEL:  prdata = {30'd0, chan_q};
			vbp_pkg::REG_STEP_TIME:      prdata = {16'd0, step_q};
			default:                     prdata = '0;
		endcase
	end

	// pipe advance
	logic en;
	logic valid_s21;
	assign en           = !(valid_s21 && result_stall);
	assign vertex_stall = !en;

	// ---------------- stage 1: axis distances, r2, height factor, paint
	logic signed [CW:0]                 dx, dz;
	logic [CW:0]                        adx, adz;
	logic [vbp_pkg::STEP_W+vbp_pkg::STRENGTH_W-1:0] st_prod;
	logic [vbp_pkg::KFAC_W-1:0]         kfac;
	logic [CSW-1:0]                     s_ext;
	logic [31:0]                        paint;

	assign dx  = $signed({hit_x[CW-1], hit_x}) - $signed({vertex_x[CW-1], vertex_x});
	assign dz  = $signed({hit_z[CW-1], hit_z}) - $signed({vertex_z[CW-1], vertex_z});
	assign adx = dx[CW] ? (CW+1)'(-dx) : dx;
	assign adz = dz[CW] ? (CW+1)'(-dz) : dz;
	assign st_prod = step_q * strength_q;
	assign s_ext   = CSW'(strength_q[vbp_pkg::STRENGTH_W-1:FRAC_BITS]);

	always_comb begin
		case (stroke_direction)
			vbp_pkg::DIR_DBL:  kfac = {st_prod, 1'b0};
			vbp_pkg::DIR_NONE: kfac = '0;
			default:           kfac = {1'b0, st_prod};
		endcase
	end

	always_comb begin
		logic signed [CSW-1:0] b;
		logic signed [CSW-1:0] v;
		for (int k = 0; k < 4; k++) begin
			b = $signed(CSW'(vertex_color[k*8 +: 8]));
			v = b;
			if (chan_q == k[1:0]) begin
				case (stroke_direction)
					vbp_pkg::DIR_UP:   v = b + $signed(s_ext);
					vbp_pkg::DIR_DOWN: v = b - $signed(s_ext);
					vbp_pkg::DIR_DBL:  v = b - $signed({s_ext[CSW-2:0], 1'b0});
					default:           v = b;
				endcase
			end else if (stroke_direction == vbp_pkg::DIR_UP) begin
				v = b - $signed(s_ext);
			end
			paint[k*8 +: 8] = vbp_pkg::clamp_byte(v);
		end
	end

	logic                        valid_s1;
	logic [vbp_pkg::DIST_W-1:0]  adx_s1, adz_s1;
	logic                        near_s1;
	logic [R2W-1:0]              r2_s1;
	logic [vbp_pkg::KFAC_W-1:0]  kfac_s1;
	logic signed [CW-1:0]        vh_s1;
	logic [31:0]                 col_s1, paint_s1;
	logic                        neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= vertex_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1   <= adx[vbp_pkg::DIST_W-1:0];
			adz_s1   <= adz[vbp_pkg::DIST_W-1:0];
			near_s1  <= (adx[CW:vbp_pkg::DIST_W] == '0) && (adz[CW:vbp_pkg::DIST_W] == '0);
			r2_s1    <= radius_q * radius_q;
			kfac_s1  <= kfac;
			vh_s1    <= vertex_height;
			col_s1   <= vertex_color;
			paint_s1 <= paint;
			neg_s1   <= stroke_direction[1];
		end
	end

	// ---------------- stage 2: squares
	logic                        valid_s2;
	logic [R2W-1:0]              sqx_s2, sqz_s2, r2_s2;
	logic                        near_s2;
	logic [vbp_pkg::KFAC_W-1:0]  kfac_s2;
	logic signed [CW-1:0]        vh_s2;
	logic [31:0]                 col_s2, paint_s2;
	logic                        neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= adx_s1 * adx_s1;
			sqz_s2   <= adz_s1 * adz_s1;
			r2_s2    <= r2_s1;
			near_s2  <= near_s1;
			kfac_s2  <= kfac_s1;
			vh_s2    <= vh_s1;
			col_s2   <= col_s1;
			paint_s2 <= paint_s1;
			neg_s2   <= neg_s1;
		end
	end

	// ---------------- stage 3: d2, inside test, falloff numerator
	logic [R2W:0]                d2;
	logic                        in_brush;
	assign d2       = {1'b0, sqx_s2} + {1'b0, sqz_s2};
	assign in_brush = near_s2 && (d2 < {1'b0, r2_s2});

	logic                        valid_s3;
	logic [R2W-1:0]              diff_s3;
	logic [vbp_pkg::KFAC_W-1:0]  kfac_s3;
	carry_t                      cy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s3        <= r2_s2 - d2[R2W-1:0];
			kfac_s3        <= kfac_s2;
			cy_s3.r2       <= r2_s2;
			cy_s3.vh       <= vh_s2;
			cy_s3.col      <= (in_brush && mode_q) ? paint_s2 : col_s2;
			cy_s3.hen      <= in_brush && !mode_q;
			cy_s3.neg      <= neg_s2;
			cy_s3.in_brush <= in_brush;
		end
	end

	// ---------------- stage 4: product, start of division
	logic [vbp_pkg::PROD_W-1:0] prod;
	assign prod = diff_s3 * kfac_s3;

	logic         valid_sd [0:QW];
	logic [R2W-1:0] rem_sd [0:QW];
	logic [QW-1:0]  low_sd [0:QW];
	logic [QW-1:0]  quo_sd [0:QW];
	carry_t         cy_sd  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sd[0] <= 1'b0;
		else if (en)
			valid_sd[0] <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= prod[vbp_pkg::PROD_W-1 -: R2W];
			low_sd[0] <= prod[2*QW-1:QW];
			quo_sd[0] <= '0;
			cy_sd[0]  <= cy_s3;
		end
	end

	// ---------------- stages 5..20: one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [R2W:0] trial;
		logic         take;
		assign trial = {rem_sd[i], low_sd[i][QW-1]};
		assign take  = trial >= {1'b0, cy_sd[i].r2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_sd[i+1] <= 1'b0;
			else if (en)
				valid_sd[i+1] <= valid_sd[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1] <= take ? R2W'(trial - {1'b0, cy_sd[i].r2}) : trial[R2W-1:0];
				low_sd[i+1] <= {low_sd[i][QW-2:0], 1'b0};
				quo_sd[i+1] <= {quo_sd[i][QW-2:0], take};
				cy_sd[i+1]  <= cy_sd[i];
			end
		end
	end

	// ---------------- stage 21: apply, saturate, hold result
	logic signed [HSW-1:0] hsum;
	logic signed [HSW-1:0] mag;
	logic signed [CW-1:0]  hsat;

	assign mag  = $signed({{(HSW-QW){1'b0}}, quo_sd[QW]});
	assign hsum = $signed({{2{cy_sd[QW].vh[CW-1]}}, cy_sd[QW].vh})
		+ (cy_sd[QW].neg ? -mag : mag);

	always_comb begin
		if (hsum[HSW-1:CW-1] == '0 || hsum[HSW-1:CW-1] == '1)
			hsat = hsum[CW-1:0];
		else if (hsum[HSW-1])
			hsat = $signed({1'b1, {(CW-1){1'b0}}});
		else
			hsat = $signed({1'b0, {(CW-1){1'b1}}});
	end

	logic signed [CW-1:0] height_s21;
	logic [31:0]          color_s21;
	logic                 inside_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s21 <= 1'b0;
		else if (en)
			valid_s21 <= valid_sd[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			height_s21 <= cy_sd[QW].hen ? hsat : cy_sd[QW].vh;
			color_s21  <= cy_sd[QW].col;
			inside_s21 <= cy_sd[QW].in_brush;
		end
	end

	assign result_valid = valid_s21;
	assign new_height   = height_s21;
	assign new_color    = color_s21;
	assign inside_brush = inside_s21;

endmodule
